// File: rtl/mfa_pkg.sv
`default_nettype none
package mfa_pkg;

   localparam int FIELD_BITS = 16;
   localparam int DENOM_BITS = FIELD_BITS - 1;
   localparam int WHOLE_SUM_BITS = FIELD_BITS + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_BITS = 32;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;

   typedef struct packed {
      logic [2:0]                   opcode;
      logic signed [FIELD_BITS-1:0] a_whole;
      logic signed [FIELD_BITS-1:0] a_numer;
      logic [DENOM_BITS-1:0]        a_denom;
      logic signed [FIELD_BITS-1:0] b_whole;
      logic signed [FIELD_BITS-1:0] b_numer;
      logic [DENOM_BITS-1:0]        b_denom;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_whole;
      logic signed [31:0] res_numer;
      logic [30:0]        res_denom;
      logic               is_less;
      logic               is_greater;
      logic               fields_equal;
      logic               zero_divisor;
      logic               overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      CLS_ADDSUB,
      CLS_MUL,
      CLS_DIV,
      CLS_CMP,
      CLS_NONE
   } op_class_type;

   typedef struct packed {
      op_class_type                 cls;
      logic                         sub;
      logic                         eq;
      logic signed [FIELD_BITS-1:0] aw;
      logic signed [FIELD_BITS-1:0] an;
      logic [DENOM_BITS-1:0]        ad;
      logic signed [FIELD_BITS-1:0] bw;
      logic signed [FIELD_BITS-1:0] bn;
      logic [DENOM_BITS-1:0]        bd;
   } job_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [DIV_BITS-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quot;
      logic [DIV_BITS-1:0] rem;
   } div_res_type;

   typedef enum logic [4:0] {
      S_IDLE, S_AS1, S_AS2, S_AS3, S_AS4,
      S_MD1, S_MD2, S_MD3,
      S_MUL1, S_MUL2, S_MUL3,
      S_DIV1, S_DIV2, S_DIV3,
      S_CMP1, S_CMP2, S_CMP3,
      S_RED, S_GCD,
      S_NG_GO, S_NG_WAIT, S_DG_GO, S_DG_WAIT, S_ND_GO, S_ND_WAIT,
      S_WHOLE, S_DONE
   } state_type;

   function automatic logic fits32(input logic signed [63:0] v);
      return (v[63:31] == '0) || (v[63:31] == '1);
   endfunction

endpackage
`default_nettype wire

// File: rtl/mfa_front.sv
`default_nettype none
module mfa_front (
   input  wire  mfa_pkg::req_type req,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire                    queue_full,
   output logic                   push,
   output mfa_pkg::job_type       job
);

   always_comb begin
      req_ready = !queue_full;
      push      = req_valid && !queue_full;
      job.sub   = (req.opcode == mfa_pkg::OP_SUB);
      case (req.opcode)
         mfa_pkg::OP_ADD, mfa_pkg::OP_SUB: job.cls = mfa_pkg::CLS_ADDSUB;
         mfa_pkg::OP_MUL: job.cls = mfa_pkg::CLS_MUL;
         mfa_pkg::OP_DIV: job.cls = mfa_pkg::CLS_DIV;
         mfa_pkg::OP_CMP: job.cls = mfa_pkg::CLS_CMP;
         default: job.cls = mfa_pkg::CLS_NONE;
      endcase
      // equality is on raw bits, before zero denominators become one
      job.eq = (req.opcode == mfa_pkg::OP_CMP) && (req.a_whole == req.b_whole) &&
               (req.a_numer == req.b_numer) && (req.a_denom == req.b_denom);
      job.aw = req.a_whole;
      job.an = req.a_numer;
      job.ad = (req.a_denom == '0) ? mfa_pkg::DENOM_BITS'(1) : req.a_denom;
      job.bw = req.b_whole;
      job.bn = req.b_numer;
      job.bd = (req.b_denom == '0) ? mfa_pkg::DENOM_BITS'(1) : req.b_denom;
   end

endmodule
`default_nettype wire

// File: rtl/mfa_queue.sv
`default_nettype none
module mfa_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire  mfa_pkg::job_type push_job,
   input  wire              pop,
   output logic             full,
   output logic             empty,
   output mfa_pkg::job_type head
);

   mfa_pkg::job_type entry_ff [mfa_pkg::QUEUE_DEPTH];
   logic [mfa_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mfa_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mfa_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == mfa_pkg::QUEUE_CNT_BITS'(mfa_pkg::QUEUE_DEPTH));
      empty     = (count_ff == '0);
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mfa_pkg::QUEUE_PTR_BITS'(mfa_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mfa_pkg::QUEUE_PTR_BITS'(mfa_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// File: rtl/mfa_divider.sv
`default_nettype none
module mfa_divider (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  mfa_pkg::div_ctl_type ctl,
   output mfa_pkg::div_res_type  res
);

   localparam int N = mfa_pkg::DIV_BITS;

   logic [N:0]   rem_ff, rem_in;
   logic [N-1:0] quot_ff, quot_in;
   logic [N-1:0] divisor_ff, divisor_in;
   logic [mfa_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [N:0] shifted;
   logic [N:0] diff;

   always_comb begin
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      shifted    = {rem_ff[N-1:0], quot_ff[N-1]};
      diff       = shifted - {1'b0, divisor_ff};
      if (ctl.start) begin
         rem_in     = '0;
         quot_in    = ctl.dividend;
         divisor_in = ctl.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (!diff[N]) begin
            rem_in  = diff;
            quot_in = {quot_ff[N-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mfa_pkg::DIV_CNT_BITS'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      res.done = done_ff;
      res.quot = quot_ff;
      res.rem  = rem_ff[N-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

endmodule
`default_nettype wire

// File: rtl/mfa_back.sv
`default_nettype none
module mfa_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  mfa_pkg::job_type head,
   input  wire                   queue_empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output mfa_pkg::rsp_type      rsp
);

   mfa_pkg::state_type   state_ff, state_in;
   mfa_pkg::job_type     job_ff, job_in;
   mfa_pkg::rsp_type     res_ff, res_in;
   mfa_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [63:0]   prod_ff, prod_in;
   logic signed [63:0]   p_ff, p_in;
   logic signed [mfa_pkg::WHOLE_SUM_BITS-1:0] w_ff, w_in;
   logic signed [31:0]   n_ff, n_in;
   logic [30:0]          d_ff, d_in;
   logic signed [31:0]   ai_ff, ai_in;
   logic signed [31:0]   bi_ff, bi_in;
   logic [31:0]          nmag_ff, nmag_in;
   logic                 nneg_ff, nneg_in;
   logic [31:0]          u_ff, u_in;
   logic [31:0]          v_ff, v_in;
   logic [4:0]           k_ff, k_in;
   logic [31:0]          g_ff, g_in;
   logic [31:0]          q_ff, q_in;
   logic [31:0]          r_ff, r_in;
   logic signed [31:0]   mul_x, mul_y;
   mfa_pkg::div_ctl_type div_ctl;
   mfa_pkg::div_res_type div_res;

   mfa_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .res   (div_res)
   );

   function automatic mfa_pkg::rsp_type saturate(input mfa_pkg::rsp_type base,
                                                 input logic neg);
      mfa_pkg::rsp_type r;
      r              = base;
      r.res_whole    = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      r.res_numer    = '0;
      r.res_denom    = 31'd1;
      r.is_less      = 1'b0;
      r.is_greater   = 1'b0;
      r.zero_divisor = 1'b0;
      r.overflowed   = 1'b1;
      return r;
   endfunction

   assign prod_in = mul_x * mul_y;

   always_comb begin
      logic signed [31:0] sa_w, sa_n, sa_d, sb_w, sb_n, sb_d;
      logic signed [31:0] bi_next;
      logic signed [63:0] nn, dd;
      logic signed [33:0] qs, whole;
      logic signed [32:0] rs;

      sa_w = 32'(job_ff.aw);
      sa_n = 32'(job_ff.an);
      sa_d = $signed(32'(job_ff.ad));
      sb_w = 32'(job_ff.bw);
      sb_n = 32'(job_ff.bn);
      sb_d = $signed(32'(job_ff.bd));
      bi_next = '0;
      nn = '0;
      dd = '0;
      qs = '0;
      whole = '0;
      rs = '0;

      state_in     = state_ff;
      job_in       = job_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      p_in         = p_ff;
      w_in         = w_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      ai_in        = ai_ff;
      bi_in        = bi_ff;
      nmag_in      = nmag_ff;
      nneg_in      = nneg_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      mul_x        = '0;
      mul_y        = '0;
      pop          = 1'b0;
      div_ctl      = '0;

      case (state_ff)
         mfa_pkg::S_IDLE: begin
            if (!queue_empty) begin
               pop    = 1'b1;
               job_in = head;
               res_in = '0;
               res_in.res_denom    = 31'd1;
               res_in.fields_equal = head.eq;
               case (head.cls)
                  mfa_pkg::CLS_ADDSUB: state_in = mfa_pkg::S_AS1;
                  mfa_pkg::CLS_MUL,
                  mfa_pkg::CLS_DIV,
                  mfa_pkg::CLS_CMP: state_in = mfa_pkg::S_MD1;
                  default: state_in = mfa_pkg::S_DONE;
               endcase
            end
         end
         mfa_pkg::S_AS1: begin
            mul_x = sa_n;
            mul_y = sb_d;
            w_in  = job_ff.sub ? mfa_pkg::WHOLE_SUM_BITS'(job_ff.aw) -
                                 mfa_pkg::WHOLE_SUM_BITS'(job_ff.bw)
                               : mfa_pkg::WHOLE_SUM_BITS'(job_ff.aw) +
                                 mfa_pkg::WHOLE_SUM_BITS'(job_ff.bw);
            state_in = mfa_pkg::S_AS2;
         end
         mfa_pkg::S_AS2: begin
            p_in  = prod_ff;
            mul_x = sb_n;
            mul_y = sa_d;
            state_in = mfa_pkg::S_AS3;
         end
         mfa_pkg::S_AS3: begin
            // cross products stay below 2^30, so their sum fits 32 bits
            n_in  = job_ff.sub ? p_ff[31:0] - prod_ff[31:0] : p_ff[31:0] + prod_ff[31:0];
            mul_x = sa_d;
            mul_y = sb_d;
            state_in = mfa_pkg::S_AS4;
         end
         mfa_pkg::S_AS4: begin
            d_in = prod_ff[30:0];
            state_in = mfa_pkg::S_RED;
         end
         mfa_pkg::S_MD1: begin
            mul_x = sa_w;
            mul_y = sa_d;
            w_in  = '0;
            state_in = mfa_pkg::S_MD2;
         end
         mfa_pkg::S_MD2: begin
            ai_in = prod_ff[31:0] + sa_n;
            mul_x = sb_w;
            mul_y = sb_d;
            state_in = mfa_pkg::S_MD3;
         end
         mfa_pkg::S_MD3: begin
            bi_next = prod_ff[31:0] + sb_n;
            bi_in   = bi_next;
            case (job_ff.cls)
               mfa_pkg::CLS_MUL: state_in = mfa_pkg::S_MUL1;
               mfa_pkg::CLS_DIV: begin
                  if (bi_next == '0) begin
                     res_in.zero_divisor = 1'b1;
                     state_in = mfa_pkg::S_DONE;
                  end else begin
                     state_in = mfa_pkg::S_DIV1;
                  end
               end
               default: state_in = mfa_pkg::S_CMP1;
            endcase
         end
         mfa_pkg::S_MUL1: begin
            mul_x = ai_ff;
            mul_y = bi_ff;
            state_in = mfa_pkg::S_MUL2;
         end
         mfa_pkg::S_MUL2: begin
            if (!mfa_pkg::fits32(prod_ff)) begin
               res_in   = saturate(res_ff, prod_ff[63]);
               state_in = mfa_pkg::S_DONE;
            end else begin
               n_in  = prod_ff[31:0];
               mul_x = sa_d;
               mul_y = sb_d;
               state_in = mfa_pkg::S_MUL3;
            end
         end
         mfa_pkg::S_MUL3: begin
            d_in = prod_ff[30:0];
            state_in = mfa_pkg::S_RED;
         end
         mfa_pkg::S_DIV1: begin
            mul_x = ai_ff;
            mul_y = sb_d;
            state_in = mfa_pkg::S_DIV2;
         end
         mfa_pkg::S_DIV2: begin
            p_in  = prod_ff;
            mul_x = sa_d;
            mul_y = bi_ff;
            state_in = mfa_pkg::S_DIV3;
         end
         mfa_pkg::S_DIV3: begin
            // move the divisor's sign onto the numerator
            nn = prod_ff[63] ? -p_ff : p_ff;
            dd = prod_ff[63] ? -prod_ff : prod_ff;
            if (!mfa_pkg::fits32(nn)) begin
               res_in   = saturate(res_ff, nn[63]);
               state_in = mfa_pkg::S_DONE;
            end else if (!mfa_pkg::fits32(dd)) begin
               res_in   = saturate(res_ff, 1'b0);
               state_in = mfa_pkg::S_DONE;
            end else begin
               n_in = nn[31:0];
               d_in = dd[30:0];
               state_in = mfa_pkg::S_RED;
            end
         end
         mfa_pkg::S_CMP1: begin
            mul_x = ai_ff;
            mul_y = sb_d;
            state_in = mfa_pkg::S_CMP2;
         end
         mfa_pkg::S_CMP2: begin
            p_in  = prod_ff;
            mul_x = bi_ff;
            mul_y = sa_d;
            state_in = mfa_pkg::S_CMP3;
         end
         mfa_pkg::S_CMP3: begin
            res_in.is_less    = (p_ff < prod_ff);
            res_in.is_greater = (p_ff > prod_ff);
            state_in = mfa_pkg::S_DONE;
         end
         mfa_pkg::S_RED: begin
            if (n_ff == '0) begin
               d_in    = 31'd1;
               q_in    = '0;
               r_in    = '0;
               nneg_in = 1'b0;
               state_in = mfa_pkg::S_WHOLE;
            end else begin
               nneg_in = n_ff[31];
               nmag_in = n_ff[31] ? 32'(-n_ff) : 32'(n_ff);
               u_in    = n_ff[31] ? 32'(-n_ff) : 32'(n_ff);
               v_in    = {1'b0, d_ff};
               k_in    = '0;
               state_in = mfa_pkg::S_GCD;
            end
         end
         mfa_pkg::S_GCD: begin
            // binary gcd, one shift or subtract per cycle
            if (u_ff == '0) begin
               g_in = v_ff << k_ff;
               state_in = mfa_pkg::S_NG_GO;
            end else if (v_ff == '0) begin
               g_in = u_ff << k_ff;
               state_in = mfa_pkg::S_NG_GO;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         mfa_pkg::S_NG_GO: begin
            div_ctl.start    = 1'b1;
            div_ctl.dividend = nmag_ff;
            div_ctl.divisor  = g_ff;
            state_in = mfa_pkg::S_NG_WAIT;
         end
         mfa_pkg::S_NG_WAIT: begin
            if (div_res.done) begin
               nmag_in  = div_res.quot;
               state_in = mfa_pkg::S_DG_GO;
            end
         end
         mfa_pkg::S_DG_GO: begin
            div_ctl.start    = 1'b1;
            div_ctl.dividend = {1'b0, d_ff};
            div_ctl.divisor  = g_ff;
            state_in = mfa_pkg::S_DG_WAIT;
         end
         mfa_pkg::S_DG_WAIT: begin
            if (div_res.done) begin
               d_in     = div_res.quot[30:0];
               state_in = mfa_pkg::S_ND_GO;
            end
         end
         mfa_pkg::S_ND_GO: begin
            div_ctl.start    = 1'b1;
            div_ctl.dividend = nmag_ff;
            div_ctl.divisor  = {1'b0, d_ff};
            state_in = mfa_pkg::S_ND_WAIT;
         end
         mfa_pkg::S_ND_WAIT: begin
            if (div_res.done) begin
               q_in     = div_res.quot;
               r_in     = div_res.rem;
               state_in = mfa_pkg::S_WHOLE;
            end
         end
         mfa_pkg::S_WHOLE: begin
            qs    = nneg_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
            rs    = nneg_ff ? -$signed({1'b0, r_ff}) : $signed({1'b0, r_ff});
            whole = 34'(w_ff) + qs;
            if ((whole[33:31] != '0) && (whole[33:31] != '1)) begin
               res_in = saturate(res_ff, whole[33]);
            end else begin
               // bring the fraction's sign in line with the whole part
               if ((whole > 0) && (rs < 0)) begin
                  whole = whole - 34'sd1;
                  rs    = rs + $signed({2'b00, d_ff});
               end else if ((whole < 0) && (rs > 0)) begin
                  whole = whole + 34'sd1;
                  rs    = rs - $signed({2'b00, d_ff});
               end
               res_in.res_whole = whole[31:0];
               res_in.res_numer = rs[31:0];
               res_in.res_denom = d_ff;
            end
            state_in = mfa_pkg::S_DONE;
         end
         mfa_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = mfa_pkg::S_IDLE;
            end
         end
         default: state_in = mfa_pkg::S_IDLE;
      endcase

      rsp_valid = rsp_valid_ff;
      rsp       = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfa_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      prod_ff <= prod_in;
      p_ff    <= p_in;
      w_ff    <= w_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
      ai_ff   <= ai_in;
      bi_ff   <= bi_in;
      nmag_ff <= nmag_in;
      nneg_ff <= nneg_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      k_ff    <= k_in;
      g_ff    <= g_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
   end

endmodule
`default_nettype wire

// File: rtl/mixed_fraction_alu_unit.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    mfa_pkg::req_type (opcode, a_*, b_*)
// rsp       out        rsp_valid/rsp_ready    mfa_pkg::rsp_type (res_*, flags)
//
// No reduction runs for an undefined opcode, a zero divisor, a compare, a multiply or
// divide overflow or a zero result; otherwise the result is reduced by binary gcd steps
// and three passes through the radix-2 divider. One transaction is worked at a time.
// A two-entry queue lets requests land while the sequencer works; req_ready drops when it
// is full, and a finished result waits in the output register while rsp_ready is low.
// Synchronous reset empties the queue and returns the sequencer to idle.
module mixed_fraction_alu_unit (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  mfa_pkg::req_type req,
   input  wire                   req_valid,
   output logic                  req_ready,
   output mfa_pkg::rsp_type      rsp,
   output logic                  rsp_valid,
   input  wire                   rsp_ready
);

   logic             queue_full;
   logic             queue_empty;
   logic             push;
   logic             pop;
   mfa_pkg::job_type push_job;
   mfa_pkg::job_type head;

   mfa_front u_front (
      .req        (req),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   mfa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head)
   );

   mfa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   a_ovf_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.overflowed |-> (rsp.res_numer == 0) && (rsp.res_denom == 1)
                                      && !rsp.zero_divisor)
      else $error("overflowed result not saturated");

   a_denom_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.res_denom != 0)
      else $error("zero result denominator");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp.is_less && rsp.is_greater))
      else $error("less and greater both set");

   a_pop_push: assert property (@(posedge clock) disable iff (reset)
      queue_empty |-> !pop)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: verif/tb_mixed_fraction_alu_unit.sv
`timescale 1ns / 1ps
module tb_mixed_fraction_alu_unit;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_ITEMS = 550;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   mfa_pkg::req_type req = '0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   mfa_pkg::rsp_type rsp;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;

   mixed_fraction_alu_unit DUT (
      .clock(clock), .reset(reset), .req(req), .req_valid(req_valid),
      .req_ready(req_ready), .rsp(rsp), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready)
   );

   always #4 clock = ~clock;

   mfa_pkg::rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      cycles = 0;

   typedef struct {
      logic    ovf;
      logic    neg;
   } ovf_track;

   function automatic longint in32(inout ovf_track t, input longint v);
      if (v > 64'sd2147483647 || v < -64'sd2147483648) begin
         if (!t.ovf) begin
            t.ovf = 1'b1;
            t.neg = v < 0;
         end
         return 0;
      end
      return v;
   endfunction

   function automatic longint den_of(input logic [mfa_pkg::DENOM_BITS-1:0] v);
      return (v == 0) ? 1 : longint'(v);
   endfunction

   function automatic longint gcd_mag(input longint a, input longint b);
      longint r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   function automatic mfa_pkg::rsp_type fraction_result(input mfa_pkg::req_type q);
      ovf_track t;
      mfa_pkg::rsp_type r;
      longint aw, an, ad, bw, bn, bd, w, n, d, p, s, ai, bi, g, wh, nm;
      logic     do_red;
      t = '{1'b0, 1'b0};
      r = '0;
      aw = q.a_whole; an = q.a_numer; ad = den_of(q.a_denom);
      bw = q.b_whole; bn = q.b_numer; bd = den_of(q.b_denom);
      w = 0; n = 0; d = 1;
      do_red = 1'b0;
      case (q.opcode)
         mfa_pkg::OP_ADD, mfa_pkg::OP_SUB: begin
            w = in32(t, q.opcode == mfa_pkg::OP_ADD ? aw + bw : aw - bw);
            p = in32(t, an * bd);
            s = in32(t, bn * ad);
            n = in32(t, q.opcode == mfa_pkg::OP_ADD ? p + s : p - s);
            d = in32(t, ad * bd);
            do_red = !t.ovf;
         end
         mfa_pkg::OP_MUL: begin
            ai = in32(t, aw * ad + an);
            bi = in32(t, bw * bd + bn);
            n = in32(t, ai * bi);
            d = in32(t, ad * bd);
            do_red = !t.ovf;
         end
         mfa_pkg::OP_DIV: begin
            ai = in32(t, aw * ad + an);
            bi = in32(t, bw * bd + bn);
            if (!t.ovf) begin
               if (bi == 0) r.zero_divisor = 1'b1;
               else begin
                  n = ai * bd;
                  d = ad * bi;
                  if (d < 0) begin
                     n = -n;
                     d = -d;
                  end
                  n = in32(t, n);
                  d = in32(t, d);
                  do_red = !t.ovf;
               end
            end
         end
         mfa_pkg::OP_CMP: begin
            r.fields_equal = (q.a_whole == q.b_whole) && (q.a_numer == q.b_numer)
                             && (q.a_denom == q.b_denom);
            ai = in32(t, aw * ad + an);
            bi = in32(t, bw * bd + bn);
            if (!t.ovf) begin
               r.is_less = ai * bd < bi * ad;
               r.is_greater = ai * bd > bi * ad;
            end
         end
         default: ;
      endcase
      r.res_denom = 31'd1;
      if (do_red) begin
         if (n == 0) d = 1;
         else begin
            g = gcd_mag(n < 0 ? -n : n, d);
            n = n / g;
            d = d / g;
         end
         wh = in32(t, w + n / d);
         nm = n % d;
         if (!t.ovf) begin
            if (wh > 0 && nm < 0) begin
               wh -= 1;
               nm += d;
            end else if (wh < 0 && nm > 0) begin
               wh += 1;
               nm -= d;
            end
            r.res_whole = 32'(wh);
            r.res_numer = 32'(nm);
            r.res_denom = 31'(d);
         end
      end
      if (t.ovf) begin
         r.res_whole = t.neg ? 32'h8000_0000 : 32'h7fff_ffff;
         r.res_numer = '0;
         r.res_denom = 31'd1;
      end
      r.overflowed = t.ovf;
      return r;
   endfunction

   function automatic mfa_pkg::req_type mk(input logic [2:0] op, input int aw, input int an,
                                           input int ad, input int bw, input int bn,
                                           input int bd);
      mfa_pkg::req_type q;
      q.opcode = op;
      q.a_whole = 16'(aw); q.a_numer = 16'(an); q.a_denom = mfa_pkg::DENOM_BITS'(ad);
      q.b_whole = 16'(bw); q.b_numer = 16'(bn); q.b_denom = mfa_pkg::DENOM_BITS'(bd);
      return q;
   endfunction

   function automatic mfa_pkg::rsp_type rs(input int w, input int n, input int d,
                                           input logic [4:0] flags);
      mfa_pkg::rsp_type r;
      r.res_whole = w; r.res_numer = n; r.res_denom = 31'(d);
      {r.is_less, r.is_greater, r.fields_equal, r.zero_divisor, r.overflowed} = flags;
      return r;
   endfunction

   function automatic int rnd_field();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32767 : -32768;
         1, 2: return int'($urandom_range(0, 40)) - 20;
         3: return int'($urandom_range(0, 600)) - 300;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   function automatic int rnd_denom();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32767 : 0;
         1, 2: return $urandom_range(1, 16);
         3: return $urandom_range(1, 300);
         default: return $urandom_range(0, 32767);
      endcase
   endfunction

   typedef struct {
      mfa_pkg::req_type q;
      logic             known;
      mfa_pkg::rsp_type r;
   } stim_row;

   stim_row rows[$];

   // sender: bursts with random gaps
   task automatic send(input mfa_pkg::req_type q);
      req <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_row(input stim_row s);
      expected_rsps.push_back(s.known ? s.r : fraction_result(s.q));
      send(s.q);
   endtask

   int burst_left = 0;

   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   initial begin
      mfa_pkg::req_type q;
      rows.push_back('{mk(mfa_pkg::OP_ADD, 0, 0, 1, 0, 0, 1), 1, rs(0, 0, 1, 5'b0)});
      rows.push_back('{mk(mfa_pkg::OP_ADD, 1, 1, 2, 0, 1, 2), 1, rs(2, 0, 1, 5'b0)});
      rows.push_back('{mk(mfa_pkg::OP_SUB, 0, 1, 2, 1, 0, 1), 1, rs(0, -1, 2, 5'b0)});
      rows.push_back('{mk(mfa_pkg::OP_MUL, 0, 0, 0, 5, 0, 0), 1, rs(0, 0, 1, 5'b0)});
      rows.push_back('{mk(mfa_pkg::OP_DIV, 3, 1, 4, 0, 0, 7), 1, rs(0, 0, 1, 5'b00010)});
      rows.push_back('{mk(mfa_pkg::OP_DIV, 1, 0, 1, 2, -4, 2), 1, rs(0, 0, 1, 5'b00010)});
      rows.push_back('{mk(mfa_pkg::OP_CMP, 1, 2, 3, 1, 2, 3), 1, rs(0, 0, 1, 5'b00100)});
      rows.push_back('{mk(mfa_pkg::OP_CMP, 0, 1, 2, 0, 2, 4), 1, rs(0, 0, 1, 5'b00000)});
      rows.push_back('{mk(mfa_pkg::OP_CMP, 0, 1, 3, 0, 1, 2), 1, rs(0, 0, 1, 5'b10000)});
      rows.push_back('{mk(mfa_pkg::OP_CMP, 0, 1, 2, 0, 1, 3), 1, rs(0, 0, 1, 5'b01000)});
      rows.push_back('{mk(3'd5, 7, 7, 7, 7, 7, 7), 1, rs(0, 0, 1, 5'b0)});
      rows.push_back('{mk(3'd7, -1, -1, 32767, -1, -1, 32767), 1, rs(0, 0, 1, 5'b0)});
      rows.push_back('{mk(mfa_pkg::OP_MUL, 32767, 32767, 32767, 32767, 32767, 32767), 1,
                       rs(32'h7fff_ffff, 0, 1, 5'b00001)});
      rows.push_back('{mk(mfa_pkg::OP_MUL, -32768, 0, 32767, 32767, 0, 32767), 1,
                       rs(32'h8000_0000, 0, 1, 5'b00001)});
      rows.push_back('{mk(mfa_pkg::OP_ADD, -32768, -32768, 1, -32768, -32768, 1), 0, '0});
      rows.push_back('{mk(mfa_pkg::OP_SUB, 32767, 32767, 32767, -32768, -32768, 32767), 0,
                       '0});
      rows.push_back('{mk(mfa_pkg::OP_DIV, -32768, -32768, 32767, 0, 1, 32767), 0, '0});
      rows.push_back('{mk(mfa_pkg::OP_DIV, 5, 3, 7, -2, 1, 3), 0, '0});
      rows.push_back('{mk(mfa_pkg::OP_CMP, -32768, 0, 32767, 32767, 0, 32767), 0, '0});
      rows.push_back('{mk(mfa_pkg::OP_ADD, 0, -3, 4, 0, 7, 6), 0, '0});
      rows.push_back('{mk(mfa_pkg::OP_SUB, 2, -5, 3, -1, 32767, 0), 0, '0});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         pace();
         send_row(rows[i]);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         q.opcode = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
         q.a_whole = 16'(rnd_field()); q.a_numer = 16'(rnd_field());
         q.a_denom = mfa_pkg::DENOM_BITS'(rnd_denom());
         if (q.opcode == mfa_pkg::OP_CMP && $urandom_range(0, 3) == 0) begin
            q.b_whole = q.a_whole; q.b_numer = q.a_numer; q.b_denom = q.a_denom;
         end else begin
            q.b_whole = 16'(rnd_field()); q.b_numer = 16'(rnd_field());
            q.b_denom = mfa_pkg::DENOM_BITS'(rnd_denom());
         end
         if (q.opcode == mfa_pkg::OP_DIV && $urandom_range(0, 7) == 0) begin
            // value-zero divisor with a nonzero pattern
            q.b_denom = mfa_pkg::DENOM_BITS'($urandom_range(1, 100));
            q.b_whole = 16'(-int'($urandom_range(0, 50)));
            q.b_numer = 16'(-(int'(q.b_whole) * int'(q.b_denom)));
         end
         pace();
         expected_rsps.push_back(fraction_result(q));
         send(q);
      end
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // receiver stall pattern: periodic with random stretches
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 1000 < 150) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0) && (cycles % 37 > 5);
   end

   always @(posedge clock) begin
      mfa_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %p", rsp);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp !== e) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, rsp);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end
endmodule

// File: files.f
rtl/mfa_pkg.sv
rtl/mfa_front.sv
rtl/mfa_queue.sv
rtl/mfa_divider.sv
rtl/mfa_back.sv
rtl/mixed_fraction_alu_unit.sv
verif/tb_mixed_fraction_alu_unit.sv
